// ----- sv/isag_pkg.sv -----
// shared constants for the icon slot allocator grid
package isag_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = SLOT_W + 1;

   localparam int ID_W     = 32;
   localparam int COORD_W  = 16;
   localparam int LIMIT_W  = 5;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DOCKED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDOCKED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd5;

   // request modes
   localparam logic MODE_DOCK   = 1'b0;
   localparam logic MODE_UNDOCK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDING    = 2'd3;

   // register reset values
   localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = 5'd8;
   localparam logic [LIMIT_W-1:0] COLUMNS_RST    = 5'd4;
   localparam logic [COORD_W-1:0] ICON_SIZE_RST  = 16'd22;
   localparam logic [COORD_W-1:0] PADDING_RST    = 16'd0;

endpackage

// ----- sv/icon_slot_allocator_grid.sv -----
// first-fit icon slot allocator with grid position sequencer
//
// Each request (one beat on req_*) is handled one at a time; req_stall is high
// while a request is in work. A dock walks the slot table from slot zero, one
// slot per cycle, up to the effective slot limit and takes the first free slot.
// The slot number is then split into row and column by repeated subtraction of
// the column count (one subtract per cycle), and the shared 16x16 multiplier
// forms the x and then the y coordinate. An undock walks the table the same
// way looking for the id and frees the first match. A request with id zero, or
// an undock with nothing docked, goes straight to its result without a walk.
// The result sits in an output register and is held while rsp_stall is high;
// the next request is accepted as soon as the result has been loaded. The
// table clears at reset through per-slot valid bits, so no clearing pass is
// needed. Configuration writes are taken at any time (csr_ready is always
// high) but must only be issued while the block idles.
module icon_slot_allocator_grid (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [isag_pkg::ID_W-1:0]             req_window_id,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [isag_pkg::STATUS_W-1:0]         rsp_status,
   output logic [isag_pkg::SLOT_W-1:0]           rsp_slot_index,
   output logic [isag_pkg::COORD_W-1:0]          rsp_x_pos,
   output logic [isag_pkg::COORD_W-1:0]          rsp_y_pos,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [isag_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [isag_pkg::CSR_DATA_W-1:0]       csr_data
);
   import isag_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MULX,
      ST_MULY,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [LIMIT_W-1:0] slot_limit_ff;
   logic [LIMIT_W-1:0] columns_ff;
   logic [COORD_W-1:0] icon_size_ff;
   logic [COORD_W-1:0] padding_ff;

   // slot table: an entry that is not valid reads as a free slot
   logic [ID_W-1:0] slot_id_ff [SLOTS];
   logic [SLOTS-1:0] slot_vld_ff;
   logic [CNT_W-1:0] occupied_ff;

   // request being worked on
   logic            mode_ff;
   logic [ID_W-1:0] id_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] row_ff;

   // work result
   logic [STATUS_W-1:0] res_status_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic [COORD_W-1:0]  res_x_ff;
   logic [COORD_W-1:0]  res_y_ff;

   // output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COORD_W-1:0]  rsp_x_ff;
   logic [COORD_W-1:0]  rsp_y_ff;

   logic [CNT_W-1:0]   eff_limit;
   logic [CNT_W-1:0]   eff_cols;
   logic [SLOT_W-1:0]  scan_idx;
   logic               scan_end;
   logic               slot_hit;
   logic [COORD_W-1:0] pitch;
   logic [CNT_W-1:0]   mul_opnd;
   logic [COORD_W-1:0] mul_prod;
   logic [COORD_W-1:0] coord;
   logic               req_take;
   logic               rsp_free;

   // limit clamped to 1..SLOTS, columns at least one
   always_comb begin
      if (slot_limit_ff == '0) begin
         eff_limit = CNT_W'(1);
      end else if (CNT_W'(slot_limit_ff) > CNT_W'(SLOTS)) begin
         eff_limit = CNT_W'(SLOTS);
      end else begin
         eff_limit = CNT_W'(slot_limit_ff);
      end
      eff_cols = (columns_ff == '0) ? CNT_W'(1) : CNT_W'(columns_ff);
   end

   // one table entry per cycle
   assign scan_idx = scan_ff[SLOT_W-1:0];
   assign scan_end = (scan_ff >= eff_limit);
   assign slot_hit = (mode_ff == MODE_DOCK) ? !slot_vld_ff[scan_idx]
                   : (slot_vld_ff[scan_idx] && (slot_id_ff[scan_idx] == id_ff));

   // shared multiplier: column in the x step, row in the y step
   assign pitch    = {padding_ff[COORD_W-2:0], 1'b0} + icon_size_ff;
   assign mul_opnd = (state_ff == ST_MULX) ? rem_ff : row_ff;
   assign mul_prod = pitch * COORD_W'(mul_opnd);
   assign coord    = padding_ff + mul_prod;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_vld_ff   <= '0;
         occupied_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         slot_limit_ff <= SLOT_LIMIT_RST;
         columns_ff    <= COLUMNS_RST;
         icon_size_ff  <= ICON_SIZE_RST;
         padding_ff    <= PADDING_RST;
      end else begin
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SLOT_LIMIT: slot_limit_ff <= csr_data[LIMIT_W-1:0];
               CSR_COLUMNS:    columns_ff    <= csr_data[LIMIT_W-1:0];
               CSR_ICON_SIZE:  icon_size_ff  <= csr_data[COORD_W-1:0];
               CSR_PADDING:    padding_ff    <= csr_data[COORD_W-1:0];
               default: ;
            endcase
         end

         // result beat taken, unless a new one is loaded in the same cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  mode_ff       <= req_mode;
                  id_ff         <= req_window_id;
                  scan_ff       <= '0;
                  res_slot_ff   <= '0;
                  res_x_ff      <= '0;
                  res_y_ff      <= '0;
                  if (req_window_id == '0) begin
                     res_status_ff <= STATUS_INVALID;
                     state_ff      <= ST_DONE;
                  end else if (req_mode == MODE_UNDOCK && occupied_ff == '0) begin
                     res_status_ff <= STATUS_EMPTY;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end

            ST_SCAN: begin
               if (scan_end) begin
                  res_status_ff <= (mode_ff == MODE_DOCK) ? STATUS_FULL
                                                          : STATUS_NOT_FOUND;
                  state_ff      <= ST_DONE;
               end else if (slot_hit) begin
                  res_slot_ff <= scan_idx;
                  if (mode_ff == MODE_DOCK) begin
                     slot_id_ff[scan_idx]  <= id_ff;
                     slot_vld_ff[scan_idx] <= 1'b1;
                     occupied_ff           <= occupied_ff + CNT_W'(1);
                     res_status_ff         <= STATUS_DOCKED;
                     rem_ff                <= scan_ff;
                     row_ff                <= '0;
                     state_ff              <= ST_DIV;
                  end else begin
                     slot_vld_ff[scan_idx] <= 1'b0;
                     occupied_ff           <= occupied_ff - CNT_W'(1);
                     res_status_ff         <= STATUS_UNDOCKED;
                     state_ff              <= ST_DONE;
                  end
               end else begin
                  scan_ff <= scan_ff + CNT_W'(1);
               end
            end

            // row and column by repeated subtraction
            ST_DIV: begin
               if (rem_ff >= eff_cols) begin
                  rem_ff <= rem_ff - eff_cols;
                  row_ff <= row_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_MULX;
               end
            end

            ST_MULX: begin
               res_x_ff <= coord;
               state_ff <= ST_MULY;
            end

            ST_MULY: begin
               res_y_ff <= coord;
               state_ff <= ST_DONE;
            end

            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_x_ff      <= res_x_ff;
                  rsp_y_ff      <= res_y_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_x_pos      = rsp_x_ff;
   assign rsp_y_pos      = rsp_y_ff;

endmodule
